FILE: rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define BFR_ASSERT_CLK(label, clock, resetn, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) prop) else $error(msg);

// assertion on the default clk and rst_n
`define BFR_ASSERT(label, prop, msg) \
    `BFR_ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

FILE: rtl/core/bfr_pkg.sv
// types, codes and helpers of the bitstream field reader
`timescale 1ns / 1ps

package bfr_pkg;

    localparam logic [3:0] OP_WRITE    = 4'd0;
    localparam logic [3:0] OP_BITS32   = 4'd1;
    localparam logic [3:0] OP_BITS64   = 4'd2;
    localparam logic [3:0] OP_SIGNED32 = 4'd3;
    localparam logic [3:0] OP_SIGNED64 = 4'd4;
    localparam logic [3:0] OP_VARINT16 = 4'd5;
    localparam logic [3:0] OP_VARINT32 = 4'd6;
    localparam logic [3:0] OP_VARINT64 = 4'd7;
    localparam logic [3:0] OP_VARINT   = 4'd8;
    localparam logic [3:0] OP_VARUINT16 = 4'd9;
    localparam logic [3:0] OP_VARUINT32 = 4'd10;
    localparam logic [3:0] OP_VARUINT64 = 4'd11;
    localparam logic [3:0] OP_VARUINT  = 4'd12;
    localparam logic [3:0] OP_VARSIZE  = 4'd13;
    localparam logic [3:0] OP_SETPOS   = 4'd14;
    localparam logic [3:0] OP_ALIGN    = 4'd15;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_EOF      = 3'd1;
    localparam logic [2:0] STAT_BADCOUNT = 3'd2;
    localparam logic [2:0] STAT_VARSIZE  = 3'd3;
    localparam logic [2:0] STAT_PASTEND  = 3'd4;

    localparam logic [3:0] FETCH_BYTES = 4'd10;
    localparam logic [6:0] MAX_SKIP    = 7'd64;
    localparam logic [63:0] VARSIZE_MAX = 64'h0000_0000_7fff_ffff;

    function automatic logic [3:0] var_max_bytes(input logic [3:0] op);
        logic [3:0] nb;
        case (op) inside
            OP_VARINT16, OP_VARUINT16: nb = 4'd2;
            OP_VARINT32, OP_VARUINT32: nb = 4'd4;
            OP_VARINT64, OP_VARUINT64: nb = 4'd8;
            OP_VARINT, OP_VARUINT:     nb = 4'd9;
            OP_VARSIZE:                nb = 4'd5;
            default:                   nb = 4'd9;
        endcase
        return nb;
    endfunction

endpackage

FILE: rtl/core/bfr_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface bfr_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  operation;
    logic [6:0]  bit_count;
    logic [15:0] target_position;
    logic [6:0]  alignment;
    logic [11:0] byte_address;
    logic [7:0]  byte_data;

    modport source (output valid, operation, bit_count, target_position, alignment,
                    byte_address, byte_data, input ready);
    modport sink (input valid, operation, bit_count, target_position, alignment,
                  byte_address, byte_data, output ready);
endinterface

interface bfr_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [2:0]  status;
    logic [15:0] new_position;

    modport source (output valid, value, status, new_position, input ready);
    modport sink (input valid, value, status, new_position, output ready);
endinterface

FILE: rtl/core/bfr_mod_unit.sv
// bit-serial remainder unit for the align request
`timescale 1ns / 1ps

module bfr_mod_unit
    import bfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [6:0]  divisor,
    output logic        done,
    output logic [6:0]  remainder
);

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  cnt_reg;
    logic [15:0] dvd_reg;
    logic [6:0]  dvs_reg;
    logic [6:0]  rem_reg;
    logic [7:0]  trial;
    logic [6:0]  rem_next;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[15]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = 7'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = trial[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[14:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/core/bitstream_field_reader_core.sv
// top level of the msb-first bitstream field reader
//
//   channel  dir  handshake       content
//   req      in   valid/ready     operation, bit_count, target_position, alignment, byte
//   rsp      out  valid/ready     value, status, new_position
//   wr       in   wr_en           stream_bit_length
//
// write byte and set position go straight to the result; a nonzero align waits on the
// bit-serial remainder unit; bit reads and varints first make ten byte reads from the
// buffer memory, then varints take one varint byte per cycle
// one request at a time; the next request is taken while a response waits
// rst_n clears position and length; the buffer memory has no reset
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bitstream_field_reader_core
    import bfr_pkg::*;
#(
    parameter int BUFFER_BYTES = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [15:0] wr_data,
    bfr_req_if.sink     req,
    bfr_rsp_if.source   rsp
);

    localparam int AW       = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int CAP_BITS = BUFFER_BYTES * 8;
    localparam int CW0      = $clog2(CAP_BITS + 1) + 1;
    localparam int CW       = (CW0 > 18) ? CW0 : 18;
    localparam logic [CW-1:0] CAP      = CW'(CAP_BITS);
    localparam logic [CW-1:0] BUF_SIZE = CW'(BUFFER_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_BYTES - 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_FETCH  = 9'b000000010,
        S_SHIFT  = 9'b000000100,
        S_BITS   = 9'b000001000,
        S_BFIN   = 9'b000010000,
        S_VAR    = 9'b000100000,
        S_VFIN   = 9'b001000000,
        S_MOD    = 9'b010000000,
        S_RESULT = 9'b100000000
    } state_t;

    state_t      state_reg;
    logic [15:0] len_reg;
    logic [15:0] pos_reg;
    logic [3:0]  op_reg;
    logic [6:0]  cnt_reg;
    logic [6:0]  align_reg;
    logic [3:0]  fcnt_reg;
    logic [AW-1:0] addr_reg;
    logic [7:0]  rdata_reg;
    logic [79:0] win_reg;
    logic [63:0] field_reg;
    logic [63:0] acc_reg;
    logic [3:0]  k_reg;
    logic [3:0]  maxb_reg;
    logic        neg_reg;
    logic [CW-1:0] vpos_reg;
    logic [63:0] res_val_reg;
    logic [2:0]  res_st_reg;
    logic [15:0] res_pos_reg;
    logic        rsp_valid_reg;
    logic [63:0] rsp_value_reg;
    logic [2:0]  rsp_status_reg;
    logic [15:0] rsp_pos_reg;

    logic [7:0]  mem [BUFFER_BYTES];

    logic [CW-1:0] eff_len;
    logic [CW-1:0] pos_w;
    logic          in_acc;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] start_addr;
    logic [AW-1:0] next_addr;
    logic          mod_start;
    logic          mod_done;
    logic [6:0]    mod_rem;
    logic [6:0]    skip;
    logic [7:0]    vbyte;
    logic          is_signed_var;
    logic          vlast;
    logic          vmore;
    logic [63:0]   vacc_next;
    logic [63:0]   vres;
    logic          sgn;
    logic [63:0]   bits_val;
    logic          bits_op;
    logic          bad_count;
    logic          bits_eof;
    logic [2:0]    idle_st;
    logic [15:0]   idle_pos;
    logic          rsp_load;

    assign eff_len = (CW'(len_reg) < CAP) ? CW'(len_reg) : CAP;
    assign pos_w   = CW'(pos_reg);
    assign in_acc  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign rsp_load  = (state_reg == S_RESULT) && (!rsp_valid_reg || rsp.ready);

    assign mem_we = in_acc && (req.operation == OP_WRITE)
                    && (CW'(req.byte_address) < BUF_SIZE);
    assign mem_re = (state_reg == S_FETCH) && (fcnt_reg < FETCH_BYTES);
    assign start_addr = (CW'(pos_reg[15:3]) < BUF_SIZE) ? AW'(pos_reg[15:3]) : '0;
    assign next_addr  = (addr_reg == LAST_ADDR) ? '0 : AW'(addr_reg + 1'b1);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[AW'(req.byte_address)] <= req.byte_data;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[addr_reg];
        end
    end

    assign mod_start = in_acc && (req.operation == OP_ALIGN) && (req.alignment != 7'd0);

    bfr_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (pos_reg),
        .divisor   (req.alignment),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign skip = 7'(align_reg - mod_rem);

    // status and position of requests settled at accept
    always_comb
    begin
        bits_op   = (req.operation == OP_BITS32) || (req.operation == OP_BITS64)
                    || (req.operation == OP_SIGNED32) || (req.operation == OP_SIGNED64);
        bad_count = (((req.operation == OP_BITS32) || (req.operation == OP_SIGNED32))
                     && (req.bit_count > 7'd32)) || (req.bit_count > 7'd64);
        bits_eof  = (req.bit_count != 7'd0) && (pos_w + CW'(req.bit_count) > eff_len);
        idle_st   = STAT_OK;
        idle_pos  = pos_reg;
        if (bits_op)
        begin
            if (bad_count)
            begin
                idle_st = STAT_BADCOUNT;
            end
            else if (bits_eof)
            begin
                idle_st = STAT_EOF;
            end
        end
        else if (req.operation == OP_SETPOS)
        begin
            if (CW'(req.target_position) > eff_len)
            begin
                idle_st = STAT_PASTEND;
            end
            else
            begin
                idle_pos = req.target_position;
            end
        end
    end

    // varint byte step
    always_comb
    begin
        vbyte         = win_reg[79:72];
        is_signed_var = (op_reg <= OP_VARINT);
        vlast         = (k_reg == 4'(maxb_reg - 4'd1));
        vmore         = 1'b0;
        if (vlast)
        begin
            vacc_next = {acc_reg[55:0], vbyte};
        end
        else if ((k_reg == 4'd0) && is_signed_var)
        begin
            vacc_next = {58'd0, vbyte[5:0]};
            vmore     = vbyte[6];
        end
        else
        begin
            vacc_next = {acc_reg[56:0], vbyte[6:0]};
            vmore     = vbyte[7];
        end
    end

    always_comb
    begin
        vres = acc_reg;
        if (is_signed_var && neg_reg)
        begin
            if ((maxb_reg == 4'd9) && (k_reg == 4'd0) && (acc_reg == 64'd0))
            begin
                vres = 64'h8000_0000_0000_0000;
            end
            else
            begin
                vres = 64'd0 - acc_reg;
            end
        end
    end

    always_comb
    begin
        sgn      = field_reg[6'(cnt_reg - 7'd1)];
        bits_val = field_reg;
        if ((op_reg == OP_SIGNED32 || op_reg == OP_SIGNED64) && (cnt_reg != 7'd0) && sgn)
        begin
            bits_val = field_reg | (~64'd0 << cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            pos_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            fcnt_reg      <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                len_reg <= wr_data;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        fcnt_reg <= '0;
                        case (req.operation) inside
                            OP_WRITE, OP_SETPOS:
                            begin
                                state_reg <= S_RESULT;
                            end
                            OP_BITS32, OP_BITS64, OP_SIGNED32, OP_SIGNED64:
                            begin
                                state_reg <= (bad_count || bits_eof) ? S_RESULT : S_FETCH;
                            end
                            OP_ALIGN:
                            begin
                                state_reg <= (req.alignment == 7'd0) ? S_RESULT : S_MOD;
                            end
                            default:
                            begin
                                state_reg <= S_FETCH;
                            end
                        endcase
                    end
                end
                S_FETCH:
                begin
                    fcnt_reg <= fcnt_reg + 4'd1;
                    if (fcnt_reg == FETCH_BYTES)
                    begin
                        state_reg <= S_SHIFT;
                    end
                end
                S_SHIFT:
                begin
                    state_reg <= (op_reg <= OP_SIGNED64) ? S_BITS : S_VAR;
                end
                S_BITS:
                begin
                    state_reg <= S_BFIN;
                end
                S_BFIN:
                begin
                    state_reg <= S_RESULT;
                end
                S_VAR:
                begin
                    if (vpos_reg + CW'(8) > eff_len)
                    begin
                        state_reg <= S_RESULT;
                    end
                    else if (vlast || !vmore)
                    begin
                        state_reg <= S_VFIN;
                    end
                end
                S_VFIN:
                begin
                    state_reg <= S_RESULT;
                end
                S_MOD:
                begin
                    if (mod_done)
                    begin
                        state_reg <= S_RESULT;
                    end
                end
                S_RESULT:
                begin
                    if (rsp_load)
                    begin
                        pos_reg   <= res_pos_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                op_reg      <= req.operation;
                cnt_reg     <= req.bit_count;
                align_reg   <= req.alignment;
                addr_reg    <= start_addr;
                maxb_reg    <= var_max_bytes(req.operation);
                k_reg       <= '0;
                acc_reg     <= '0;
                neg_reg     <= 1'b0;
                vpos_reg    <= pos_w;
                res_val_reg <= '0;
                res_st_reg  <= idle_st;
                res_pos_reg <= idle_pos;
            end
            S_FETCH:
            begin
                if (mem_re)
                begin
                    addr_reg <= next_addr;
                end
                if (fcnt_reg != 4'd0)
                begin
                    win_reg <= {win_reg[71:0], rdata_reg};
                end
            end
            S_SHIFT:
            begin
                win_reg <= win_reg << pos_reg[2:0];
            end
            S_BITS:
            begin
                field_reg <= (cnt_reg == 7'd0) ? 64'd0 : (win_reg[79:16] >> (7'd64 - cnt_reg));
            end
            S_BFIN:
            begin
                res_val_reg <= bits_val;
                res_pos_reg <= 16'(pos_reg + {9'd0, cnt_reg});
            end
            S_VAR:
            begin
                if (vpos_reg + CW'(8) > eff_len)
                begin
                    res_st_reg <= STAT_EOF;
                end
                else
                begin
                    vpos_reg <= vpos_reg + CW'(8);
                    win_reg  <= {win_reg[71:0], 8'd0};
                    acc_reg  <= vacc_next;
                    if ((k_reg == 4'd0) && is_signed_var && !vlast)
                    begin
                        neg_reg <= vbyte[7];
                    end
                    if (!(vlast || !vmore))
                    begin
                        k_reg <= k_reg + 4'd1;
                    end
                end
            end
            S_VFIN:
            begin
                if ((op_reg == OP_VARSIZE) && (vres > VARSIZE_MAX))
                begin
                    res_st_reg <= STAT_VARSIZE;
                end
                else
                begin
                    res_val_reg <= vres;
                    res_pos_reg <= vpos_reg[15:0];
                end
            end
            S_MOD:
            begin
                if (mod_done && (mod_rem != 7'd0))
                begin
                    if (skip > MAX_SKIP)
                    begin
                        res_st_reg <= STAT_BADCOUNT;
                    end
                    else if (pos_w + CW'(skip) > eff_len)
                    begin
                        res_st_reg <= STAT_EOF;
                    end
                    else
                    begin
                        res_pos_reg <= 16'(pos_reg + {9'd0, skip});
                    end
                end
            end
            S_RESULT:
            begin
                if (rsp_load)
                begin
                    rsp_value_reg  <= res_val_reg;
                    rsp_status_reg <= res_st_reg;
                    rsp_pos_reg    <= res_pos_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.value        = rsp_value_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.new_position = rsp_pos_reg;

    `BFR_ASSERT(a_fetch_bound, (state_reg == S_FETCH) |-> (fcnt_reg <= FETCH_BYTES), "fetch count overrun")
    `BFR_ASSERT(a_err_zero, (rsp_valid_reg && rsp_status_reg != STAT_OK) |-> (rsp_value_reg == 64'd0), "failed request with nonzero value")
    `BFR_ASSERT(a_pos_update, !$stable(pos_reg) |-> ($past(state_reg) == S_RESULT), "position changed outside result")

endmodule
